// File: rtl/core/fdr_pkg.sv
package fdr_pkg;

  localparam int VecFrac  = 16;
  localparam int IdxFrac  = 12;
  localparam int CoefFrac = 16;

  localparam int ONE      = 1 << VecFrac;
  localparam int HALF_F   = 1 << (VecFrac - 1);
  localparam longint unsigned ONE_SQ = 64'd1 << (2 * VecFrac);
  localparam int W_SHIFT  = VecFrac + CoefFrac - IdxFrac;
  localparam int W_HALF   = 1 << (W_SHIFT - 1);

  localparam logic [19:0] ETA_MAX = 20'hFFFFF;
  localparam logic [15:0] W_MAX   = 16'hFFFF;

  localparam logic CFG_EXTERIOR = 1'b0;
  localparam logic CFG_INTERIOR = 1'b1;

  // pipeline stage map
  localparam int S_MUL   = 0;
  localparam int S_SUM   = 1;
  localparam int S_SIDE  = 2;
  localparam int S_EDIV  = 3;
  localparam int EDIV_N  = 20;
  localparam int S_ESAT  = S_EDIV + EDIV_N;
  localparam int S_SQR   = S_ESAT + 1;
  localparam int S_RND   = S_SQR + 1;
  localparam int S_KMUL  = S_RND + 1;
  localparam int S_K     = S_KMUL + 1;
  localparam int S_ROOT  = S_K + 1;
  localparam int ROOT_N  = 17;
  localparam int S_MDIFF = S_ROOT + ROOT_N;
  localparam int S_MUL2  = S_MDIFF + 1;
  localparam int S_DIR   = S_MUL2 + 1;
  localparam int S_AMP   = S_DIR + 1;
  localparam int AMP_N   = 17;
  localparam int S_AMPF  = S_AMP + AMP_N;
  localparam int S_SQ    = S_AMPF + 1;
  localparam int S_TRANS = S_SQ + 1;
  localparam int S_WMUL  = S_TRANS + 1;
  localparam int S_WGT   = S_WMUL + 1;
  localparam int NSTG    = S_WGT + 1;

  typedef struct {
    logic signed [18:0] n [3];
    logic signed [17:0] v [3];
    logic signed [35:0] p [3];
    logic signed [37:0] c;
    logic [16:0]        cq;
    logic [13:0]        num;
    logic [13:0]        den;
    logic               sat;
    logic [14:0]        erem;
    logic [19:0]        eta;
    logic [39:0]        pe2;
    logic [33:0]        pc2;
    logic [36:0]        pca;
    logic [24:0]        eta2;
    logic [16:0]        sin2;
    logic [20:0]        a;
    logic [40:0]        pk;
    logic               tir;
    logic [33:0]        rad;
    logic [20:0]        srem;
    logic [16:0]        ct;
    logic signed [21:0] m;
    logic [36:0]        pect;
    logic [20:0]        ect;
    logic signed [38:0] pv [3];
    logic signed [40:0] pm [3];
    logic signed [17:0] t [3];
    logic [21:0]        rp_den;
    logic [21:0]        rs_den;
    logic [22:0]        rp_rem;
    logic [22:0]        rs_rem;
    logic [16:0]        rp;
    logic [16:0]        rs;
    logic               rp_z;
    logic               rs_z;
    logic [33:0]        sqp;
    logic [33:0]        sqs;
    logic [16:0]        trans;
    logic [41:0]        pw;
    logic [15:0]        w;
  } fdr_stage_t;

endpackage

// File: rtl/core/fresnel_dielectric_refraction.sv
// Refraction of a ray through a dielectric surface with unpolarised Fresnel
// transmission. Each transfer on the input carries a unit normal and a unit
// outgoing direction (signed Q1.16); the result carries the transmitted
// direction, the transmission coefficient (unsigned Q1.16), the radiance weight
// (Q4.12, saturating) and a total-internal-reflection flag in tuser, with all
// data zero when that flag is set. The block is a 70-stage pipeline that
// takes one item every cycle while the skid buffer is empty; out_tvalid rises
// once the item has passed the 70 stages and the output register.
// Depth is set by the index divider (one quotient bit per stage), the square
// root (one result bit per stage) and the two Fresnel amplitude dividers.
// A one-entry skid buffer behind the output register keeps the input open
// while a result waits. Index registers may be written only while idle.
module fresnel_dielectric_refraction (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // normal_x, normal_y, normal_z, view_x, view_y, view_z (18 bits each)
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // trans_x, trans_y, trans_z (18 each), transmission (17), weight (16)
  output logic [87:0]  out_tdata,
  // total_reflect
  output logic         out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [13:0]  cfg_data
);
  import fdr_pkg::*;

  logic [13:0] ext_idx_r;
  logic [13:0] int_idx_r;

  fdr_stage_t in_st;
  fdr_stage_t pipe_r  [NSTG];
  fdr_stage_t stg_nxt [NSTG];
  logic [NSTG-1:0] vld_r;
  logic en;

  logic [86:0] res;
  logic [86:0] out_data_r;
  logic        out_user_r;
  logic        out_vld_r;
  logic [86:0] skid_data_r;
  logic        skid_user_r;
  logic        skid_vld_r;
  logic        take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_idx_r <= 14'd4096;
      int_idx_r <= 14'd6226;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_EXTERIOR: ext_idx_r <= cfg_data;
        CFG_INTERIOR: int_idx_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_st = '{default: '0};
    for (int i = 0; i < 3; i++) begin
      in_st.n[i] = 19'($signed(in_tdata[18*i +: 18]));
      in_st.v[i] = $signed(in_tdata[54 + 18*i +: 18]);
    end
  end

  assign en        = !skid_vld_r;
  assign in_tready = en;

  for (genvar s = 0; s < NSTG; s++) begin : g_stg
    fdr_stage_t src;
    if (s == 0) begin : g_src0
      assign src = in_st;
    end else begin : g_srcn
      assign src = pipe_r[s-1];
    end

    if (s == S_MUL) begin : g_mul
      always_comb begin
        stg_nxt[s] = src;
        for (int i = 0; i < 3; i++) stg_nxt[s].p[i] = src.n[i] * src.v[i];
      end
    end else if (s == S_SUM) begin : g_sum
      always_comb begin
        stg_nxt[s] = src;
        stg_nxt[s].c = 38'(src.p[0]) + 38'(src.p[1]) + 38'(src.p[2]);
      end
    end else if (s == S_SIDE) begin : g_side
      always_comb begin
        logic [36:0] cabs;
        logic [21:0] cr;
        stg_nxt[s] = src;
        if (src.c < 0) begin
          for (int i = 0; i < 3; i++) stg_nxt[s].n[i] = -src.n[i];
          cabs = 37'(-src.c);
          stg_nxt[s].num = int_idx_r;
          stg_nxt[s].den = ext_idx_r;
        end else begin
          cabs = 37'(src.c);
          stg_nxt[s].num = ext_idx_r;
          stg_nxt[s].den = int_idx_r;
        end
        cr = 22'((cabs + 37'(HALF_F)) >> VecFrac);
        stg_nxt[s].cq   = (cr > 22'(ONE)) ? 17'(ONE) : cr[16:0];
        stg_nxt[s].sat  = {4'b0, stg_nxt[s].num} >= {stg_nxt[s].den, 4'b0};
        stg_nxt[s].erem = 15'(stg_nxt[s].num >> 4);
        stg_nxt[s].eta  = '0;
      end
    end else if (s >= S_EDIV && s < S_EDIV + EDIV_N) begin : g_ediv
      localparam int J = EDIV_N - 1 - (s - S_EDIV);
      always_comb begin
        logic [29:0] dvd;
        logic [14:0] rc;
        stg_nxt[s] = src;
        dvd = {src.num, 16'b0};
        rc  = {src.erem[13:0], dvd[J]};
        if (rc >= {1'b0, src.den}) begin
          stg_nxt[s].erem   = rc - {1'b0, src.den};
          stg_nxt[s].eta[J] = 1'b1;
        end else begin
          stg_nxt[s].erem = rc;
        end
      end
    end else if (s == S_ESAT) begin : g_esat
      always_comb begin
        stg_nxt[s] = src;
        if (src.sat) stg_nxt[s].eta = ETA_MAX;
      end
    end else if (s == S_SQR) begin : g_sqr
      always_comb begin
        stg_nxt[s] = src;
        stg_nxt[s].pe2 = src.eta * src.eta;
        stg_nxt[s].pc2 = src.cq * src.cq;
        stg_nxt[s].pca = src.cq * src.eta;
      end
    end else if (s == S_RND) begin : g_rnd
      always_comb begin
        stg_nxt[s] = src;
        stg_nxt[s].eta2 = 25'((src.pe2 + 40'(HALF_F)) >> VecFrac);
        stg_nxt[s].sin2 = 17'((34'(ONE_SQ) - src.pc2 + 34'(HALF_F)) >> VecFrac);
        stg_nxt[s].a    = 21'((src.pca + 37'(HALF_F)) >> VecFrac);
      end
    end else if (s == S_KMUL) begin : g_kmul
      always_comb begin
        stg_nxt[s] = src;
        stg_nxt[s].pk = src.eta2 * src.sin2;
      end
    end else if (s == S_K) begin : g_k
      always_comb begin
        stg_nxt[s] = src;
        stg_nxt[s].tir  = src.pk > 41'(ONE_SQ);
        stg_nxt[s].rad  = 34'(41'(ONE_SQ) - src.pk);
        stg_nxt[s].srem = '0;
        stg_nxt[s].ct   = '0;
      end
    end else if (s >= S_ROOT && s < S_ROOT + ROOT_N) begin : g_root
      localparam int I = ROOT_N - 1 - (s - S_ROOT);
      always_comb begin
        logic [22:0] rc;
        logic [22:0] trial;
        stg_nxt[s] = src;
        rc    = {src.srem, src.rad[2*I +: 2]};
        trial = {4'b0, src.ct, 2'b01};
        if (rc >= trial) begin
          stg_nxt[s].srem = 21'(rc - trial);
          stg_nxt[s].ct   = {src.ct[15:0], 1'b1};
        end else begin
          stg_nxt[s].srem = rc[20:0];
          stg_nxt[s].ct   = {src.ct[15:0], 1'b0};
        end
      end
    end else if (s == S_MDIFF) begin : g_mdiff
      always_comb begin
        stg_nxt[s] = src;
        stg_nxt[s].m    = $signed({1'b0, src.a}) - $signed({5'b0, src.ct});
        stg_nxt[s].pect = src.eta * src.ct;
      end
    end else if (s == S_MUL2) begin : g_mul2
      always_comb begin
        stg_nxt[s] = src;
        stg_nxt[s].ect = 21'((src.pect + 37'(HALF_F)) >> VecFrac);
        for (int i = 0; i < 3; i++) begin
          stg_nxt[s].pv[i] = src.v[i] * $signed({1'b0, src.eta});
          stg_nxt[s].pm[i] = src.m * src.n[i];
        end
      end
    end else if (s == S_DIR) begin : g_dir
      always_comb begin
        logic signed [41:0] ts;
        logic signed [21:0] d;
        logic [20:0] an;
        logic [20:0] bn;
        stg_nxt[s] = src;
        for (int i = 0; i < 3; i++) begin
          ts = (42'(src.pm[i]) - 42'(src.pv[i]) + 42'(HALF_F)) >>> VecFrac;
          if (ts > ONE) stg_nxt[s].t[i] = 18'(ONE);
          else if (ts < -ONE) stg_nxt[s].t[i] = -18'(ONE);
          else stg_nxt[s].t[i] = ts[17:0];
        end
        an = (src.m < 0) ? 21'(-src.m) : 21'(src.m);
        d  = $signed({5'b0, src.cq}) - $signed({1'b0, src.ect});
        bn = (d < 0) ? 21'(-d) : 21'(d);
        stg_nxt[s].rp_den = 22'(src.a) + 22'(src.ct);
        stg_nxt[s].rs_den = 22'(src.cq) + 22'(src.ect);
        stg_nxt[s].rp_z   = stg_nxt[s].rp_den == '0;
        stg_nxt[s].rs_z   = stg_nxt[s].rs_den == '0;
        stg_nxt[s].rp_rem = 23'(an);
        stg_nxt[s].rs_rem = 23'(bn);
        stg_nxt[s].rp     = '0;
        stg_nxt[s].rs     = '0;
      end
    end else if (s >= S_AMP && s < S_AMP + AMP_N) begin : g_amp
      localparam int J = AMP_N - 1 - (s - S_AMP);
      always_comb begin
        logic [22:0] rcp;
        logic [22:0] rcs;
        stg_nxt[s] = src;
        rcp = (J == AMP_N - 1) ? src.rp_rem : {src.rp_rem[21:0], 1'b0};
        rcs = (J == AMP_N - 1) ? src.rs_rem : {src.rs_rem[21:0], 1'b0};
        if (rcp >= {1'b0, src.rp_den}) begin
          stg_nxt[s].rp_rem = rcp - {1'b0, src.rp_den};
          stg_nxt[s].rp[J]  = 1'b1;
        end else begin
          stg_nxt[s].rp_rem = rcp;
        end
        if (rcs >= {1'b0, src.rs_den}) begin
          stg_nxt[s].rs_rem = rcs - {1'b0, src.rs_den};
          stg_nxt[s].rs[J]  = 1'b1;
        end else begin
          stg_nxt[s].rs_rem = rcs;
        end
      end
    end else if (s == S_AMPF) begin : g_ampf
      always_comb begin
        stg_nxt[s] = src;
        if (src.rp_z) stg_nxt[s].rp = 17'(ONE);
        if (src.rs_z) stg_nxt[s].rs = 17'(ONE);
      end
    end else if (s == S_SQ) begin : g_sq
      always_comb begin
        stg_nxt[s] = src;
        stg_nxt[s].sqp = src.rp * src.rp;
        stg_nxt[s].sqs = src.rs * src.rs;
      end
    end else if (s == S_TRANS) begin : g_trans
      always_comb begin
        logic [34:0] sum;
        logic [18:0] half;
        stg_nxt[s] = src;
        sum  = 35'(src.sqp) + 35'(src.sqs);
        half = 19'((sum + 35'(ONE)) >> (CoefFrac + 1));
        stg_nxt[s].trans = (half >= 19'(ONE)) ? '0 : 17'(19'(ONE) - half);
      end
    end else if (s == S_WMUL) begin : g_wmul
      always_comb begin
        stg_nxt[s] = src;
        stg_nxt[s].pw = src.trans * src.eta2;
      end
    end else begin : g_wgt
      always_comb begin
        logic [22:0] wr;
        stg_nxt[s] = src;
        wr = 23'((src.pw + 42'(W_HALF)) >> W_SHIFT);
        stg_nxt[s].w = (wr > 23'(W_MAX)) ? W_MAX : wr[15:0];
        if (src.tir) begin
          for (int i = 0; i < 3; i++) stg_nxt[s].t[i] = '0;
          stg_nxt[s].trans = '0;
          stg_nxt[s].w     = '0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) pipe_r[s] <= stg_nxt[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  assign res = {pipe_r[NSTG-1].w, pipe_r[NSTG-1].trans, pipe_r[NSTG-1].t[2],
                pipe_r[NSTG-1].t[1], pipe_r[NSTG-1].t[0]};
  assign take = vld_r[NSTG-1] && en;

  // output register with a one-entry skid behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_tready || !out_vld_r) begin
      if (skid_vld_r) begin
        out_data_r <= skid_data_r;
        out_user_r <= skid_user_r;
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else if (take) begin
        out_data_r <= res;
        out_user_r <= pipe_r[NSTG-1].tir;
        out_vld_r  <= 1'b1;
      end else begin
        out_vld_r <= 1'b0;
      end
    end else if (take) begin
      skid_data_r <= res;
      skid_user_r <= pipe_r[NSTG-1].tir;
      skid_vld_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_data_r};
  assign out_tuser  = out_user_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds a result while output register is empty");

  a_tir_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("total reflection result carries non-zero data");

  a_trans_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[70:54] <= 17'(ONE)))
    else $error("transmission above one");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without a waiting result");

endmodule

// File: test/fresnel_dielectric_refraction_tb.sv
`timescale 1ns / 1ps

module fresnel_dielectric_refraction_tb;
  import fdr_pkg::*;

  typedef struct {
    logic signed [17:0] nx, ny, nz, vx, vy, vz;
  } hit_t;

  typedef struct {
    logic signed [17:0] tx, ty, tz;
    logic [16:0]        trans;
    logic [15:0]        weight;
    logic               tir;
  } refr_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [111:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [87:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_index;
  logic [13:0]  cfg_data;

  refr_t       pending_refr[$];
  logic [13:0] ext_idx;
  logic [13:0] int_idx;
  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_req;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  int          errors;

  fresnel_dielectric_refraction u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic longint rnd_half_up(longint x, int s);
    return (x + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint amp_mag(longint num, longint den);
    if (den <= 0) return longint'(1) << 16;
    return ((num < 0 ? -num : num) << 16) / den;
  endfunction

  function automatic refr_t refract(hit_t h);
    refr_t  r;
    longint one, n[3], v[3], c, cq, num, den, eta, eta2, sin2, k, ct, a, m, t;
    longint ect, rp, rs, half, trans, w;
    one  = longint'(1) << 16;
    n[0] = h.nx; n[1] = h.ny; n[2] = h.nz;
    v[0] = h.vx; v[1] = h.vy; v[2] = h.vz;
    c    = n[0] * v[0] + n[1] * v[1] + n[2] * v[2];
    num  = ext_idx;
    den  = int_idx;
    if (c < 0) begin
      for (int i = 0; i < 3; i++) n[i] = -n[i];
      c   = -c;
      num = int_idx;
      den = ext_idx;
    end
    cq = rnd_half_up(c, 16);
    if (cq > one) cq = one;
    eta = (den == 0) ? longint'(ETA_MAX) : (num << 16) / den;
    if (eta > longint'(ETA_MAX)) eta = longint'(ETA_MAX);
    eta2 = rnd_half_up(eta * eta, 16);
    sin2 = rnd_half_up((one << 16) - cq * cq, 16);
    k    = (one << 16) - eta2 * sin2;
    r    = '{tx: '0, ty: '0, tz: '0, trans: '0, weight: '0, tir: 1'b1};
    if (k < 0) return r;
    ct = floor_sqrt(k);
    a  = rnd_half_up(cq * eta, 16);
    m  = a - ct;
    for (int i = 0; i < 3; i++) begin
      t = rnd_half_up(-v[i] * eta + m * n[i], 16);
      if (t > one) t = one;
      if (t < -one) t = -one;
      if (i == 0) r.tx = t[17:0];
      else if (i == 1) r.ty = t[17:0];
      else r.tz = t[17:0];
    end
    ect   = rnd_half_up(eta * ct, 16);
    rp    = amp_mag(a - ct, a + ct);
    rs    = amp_mag(cq - ect, cq + ect);
    half  = (rp * rp + rs * rs + one) >> 17;
    trans = (half >= one) ? 0 : one - half;
    w     = (trans * eta2 + (longint'(1) << 19)) >> 20;
    if (w > 65535) w = 65535;
    r.trans  = trans[16:0];
    r.weight = w[15:0];
    r.tir    = 1'b0;
    return r;
  endfunction

  task automatic send_hit(hit_t h);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, h.vz, h.vy, h.vx, h.nz, h.ny, h.nx};
    do @(posedge clk); while (!in_tready);
    pending_refr.push_back(refract(h));
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_refr.size() != 0) @(posedge clk);
  endtask

  task automatic write_index(logic idx, logic [13:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_EXTERIOR) ext_idx = val;
    else int_idx = val;
  endtask

  function automatic hit_t make_hit(int nz_, int vx_, int vz_);
    hit_t h;
    h = '{nx: '0, ny: '0, nz: 18'(nz_), vx: 18'(vx_), vy: '0, vz: 18'(vz_)};
    return h;
  endfunction

  function automatic logic signed [17:0] to_fix(real x);
    return 18'($rtoi(x * 65536.0 + (x < 0 ? -0.5 : 0.5)));
  endfunction

  function automatic hit_t random_hit();
    hit_t h;
    real  a[6], ln, lv;
    if ($urandom_range(99) < 15) begin
      h = '{nx: 18'($urandom), ny: 18'($urandom), nz: 18'($urandom),
            vx: 18'($urandom), vy: 18'($urandom), vz: 18'($urandom)};
      return h;
    end
    do begin
      for (int i = 0; i < 6; i++) a[i] = $itor($urandom_range(2000)) - 1000.0;
      ln = $sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
      lv = $sqrt(a[3] * a[3] + a[4] * a[4] + a[5] * a[5]);
    end while (ln < 1.0 || lv < 1.0);
    h.nx = to_fix(a[0] / ln); h.ny = to_fix(a[1] / ln); h.nz = to_fix(a[2] / ln);
    h.vx = to_fix(a[3] / lv); h.vy = to_fix(a[4] / lv); h.vz = to_fix(a[5] / lv);
    return h;
  endfunction

  always @(posedge clk) begin
    if (hold_req && !hold_seen) begin
      out_tready <= 1'b0;
      hold_seen  <= 1'b1;
      hold_left  <= 399;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    refr_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_refr.size() == 0) begin
        $error("unexpected transfer on output");
        errors++;
      end else begin
        e = pending_refr.pop_front();
        if (out_tdata[17:0] !== e.tx) begin
          $error("trans_x exp %0d got %0d", e.tx, $signed(out_tdata[17:0]));
          errors++;
        end
        if (out_tdata[35:18] !== e.ty) begin
          $error("trans_y exp %0d got %0d", e.ty, $signed(out_tdata[35:18]));
          errors++;
        end
        if (out_tdata[53:36] !== e.tz) begin
          $error("trans_z exp %0d got %0d", e.tz, $signed(out_tdata[53:36]));
          errors++;
        end
        if (out_tdata[70:54] !== e.trans) begin
          $error("transmission exp %0d got %0d", e.trans, out_tdata[70:54]);
          errors++;
        end
        if (out_tdata[86:71] !== e.weight) begin
          $error("weight exp %0d got %0d", e.weight, out_tdata[86:71]);
          errors++;
        end
        if (out_tuser !== e.tir) begin
          $error("total_reflect exp %0d got %0d", e.tir, out_tuser);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    hit_t h;
    send_hit(make_hit(65536, 0, 65536));
    send_hit(make_hit(65536, 0, -65536));
    send_hit(make_hit(65536, 65536, 0));
    send_hit(make_hit(65536, 46341, 46341));
    send_hit(make_hit(65536, 46341, -46341));
    send_hit(make_hit(65536, 60000, -26000));
    send_hit(make_hit(-65536, 0, 65536));
    send_hit(make_hit(0, 0, 0));
    send_hit(make_hit(65536, 65536, 1));
    send_hit(make_hit(65536, 65536, -1));
    h = '{nx: 18'(-131072), ny: 18'(-131072), nz: 18'(-131072),
          vx: 18'(-131072), vy: 18'(-131072), vz: 18'(-131072)};
    send_hit(h);
    h = '{nx: 18'(131071), ny: 18'(131071), nz: 18'(131071),
          vx: 18'(-131072), vy: 18'(-131072), vz: 18'(-131072)};
    send_hit(h);
    h = '{nx: 18'(131071), ny: 18'(-131072), nz: 18'(131071),
          vx: 18'(131071), vy: 18'(131071), vz: 18'(-131072)};
    send_hit(h);
    h = '{nx: 18'(37837), ny: 18'(37837), nz: 18'(37837),
          vx: 18'(-37837), vy: 18'(37837), vz: 18'(-37837)};
    send_hit(h);
    drain();
  endtask

  task automatic test_random_phases(int n_per);
    int modes[4][2] = '{'{0, 0}, '{83, 0}, '{0, 83}, '{18, 18}};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = modes[p][0];
      recv_stall_pct = modes[p][1];
      for (int i = 0; i < n_per; i++) send_hit(random_hit());
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 120; i++) send_hit(random_hit());
    drain();
  endtask

  task automatic test_index_settings();
    write_index(CFG_EXTERIOR, 14'd16383);
    write_index(CFG_INTERIOR, 14'd4096);
    test_random_phases(10);
    write_index(CFG_INTERIOR, 14'd16383);
    test_random_phases(8);
    write_index(CFG_EXTERIOR, 14'd4096);
    test_random_phases(8);
    write_index(CFG_EXTERIOR, 14'd0);
    write_index(CFG_INTERIOR, 14'd9000);
    test_directed();
    write_index(CFG_INTERIOR, 14'd0);
    write_index(CFG_EXTERIOR, 14'd5000);
    test_random_phases(5);
    write_index(CFG_EXTERIOR, 14'($urandom_range(4096, 16383)));
    write_index(CFG_INTERIOR, 14'($urandom_range(4096, 16383)));
    test_random_phases(10);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_EXTERIOR;
    cfg_data       = '0;
    ext_idx        = 14'd4096;
    int_idx        = 14'd6226;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    errors         = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phases(40);
    test_backpressure();
    test_index_settings();
    repeat (100) @(posedge clk);
    if (errors == 0 && pending_refr.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: fresnel_dielectric_refraction.f
rtl/core/fdr_pkg.sv
rtl/core/fresnel_dielectric_refraction.sv
test/fresnel_dielectric_refraction_tb.sv
